// File: design/rtpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpd_pkg
// Shared types, constants and code-tier tables of the rank tiered prefix
// decoder.
// ----------------------------------------------------------------------------
package rtpd_pkg;

   localparam int ALPHABET_SIZE = 256;
   localparam int SYM_W         = 8;
   localparam int POS_W         = 9;
   localparam int PAYLOAD_POS   = ALPHABET_SIZE + 1;
   localparam int ACC_W         = 20;
   localparam int CNT_W         = 5;
   localparam int ONES_W        = 3;
   localparam int LEN_W         = 4;
   localparam int RANK_W        = 9;
   localparam int NB_W          = 4;
   localparam int EMIT_W        = 3;
   localparam int MAX_RESULTS   = 4;
   localparam int MAX_ONES      = 5;

   typedef enum logic [1:0] {
      KIND_SYMBOL = 2'd0,
      KIND_END    = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     sym_ok;
      logic     last;
   } result_type;

   // payload bits after the prefix, per count of leading ones
   function automatic logic [LEN_W-1:0] tier_width(input logic [ONES_W-1:0] ones);
      case (ones)
         3'd0:    tier_width = 4'd2;
         3'd1:    tier_width = 4'd3;
         3'd2:    tier_width = 4'd4;
         3'd3:    tier_width = 4'd6;
         default: tier_width = 4'd8;
      endcase
   endfunction

   function automatic logic [RANK_W-1:0] tier_base(input logic [ONES_W-1:0] ones);
      case (ones)
         3'd0:    tier_base = 9'd0;
         3'd1:    tier_base = 9'd4;
         3'd2:    tier_base = 9'd12;
         3'd3:    tier_base = 9'd28;
         default: tier_base = 9'd92;
      endcase
   endfunction

   // whole code length, prefix included
   function automatic logic [LEN_W-1:0] tier_len(input logic [ONES_W-1:0] ones);
      case (ones)
         3'd0:    tier_len = 4'd3;
         3'd1:    tier_len = 4'd5;
         3'd2:    tier_len = 4'd7;
         3'd3:    tier_len = 4'd10;
         default: tier_len = 4'd13;
      endcase
   endfunction

   function automatic logic [SYM_W-1:0] tier_mask(input logic [ONES_W-1:0] ones);
      case (ones)
         3'd0:    tier_mask = 8'h03;
         3'd1:    tier_mask = 8'h07;
         3'd2:    tier_mask = 8'h0f;
         3'd3:    tier_mask = 8'h3f;
         default: tier_mask = 8'hff;
      endcase
   endfunction

endpackage

// File: design/rtpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rtpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rank_tiered_prefix_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_tiered_prefix_decoder_unit
// Decodes a byte stream made of a count byte, a rank header and tiered
// prefix codes into symbols, with end and error markers.
// ----------------------------------------------------------------------------
// Each stream starts with a count byte (valid bits of the final byte, 0 or
// above 7 meaning eight) and 256 rank bytes, taken at one byte per cycle;
// the inverse rank table lives in a 256 x 8 RAM with registered read, and a
// flop per entry marks ranks already claimed, cleared at the end of each
// stream. Payload bytes are decoded by a code extractor that retires one
// complete code per cycle while the staging register can take its result,
// and then closes the byte in the same cycle as the next byte is accepted.
// Symbols are looked up in the RAM and leave through a staging register
// and the output register, one per cycle while the output is not stalled.
// The final byte (tlast) ends the stream with an end marker; a prefix of
// five ones or a rank beyond the table gives an error marker and the rest
// of that stream is dropped silently.
// ----------------------------------------------------------------------------
module rank_tiered_prefix_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,   // end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // symbol
   output logic [1:0] rsp_tuser,   // kind
   output logic       rsp_tlast    // last
);

   localparam int ACC_W  = rtpd_pkg::ACC_W;
   localparam int CNT_W  = rtpd_pkg::CNT_W;
   localparam int POS_W  = rtpd_pkg::POS_W;
   localparam int SYM_W  = rtpd_pkg::SYM_W;
   localparam int ASIZE  = rtpd_pkg::ALPHABET_SIZE;

   // stream state
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [3:0]               vbl_ff, vbl_in;
   logic [ASIZE-1:0]         ivalid_ff, ivalid_in;
   logic                     err_ff, err_in;
   // code extractor
   logic                     busy_ff, busy_in;
   logic                     eos_ff, eos_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [rtpd_pkg::EMIT_W-1:0] nemit_ff, nemit_in;
   // result staging and output
   logic                     b_valid_ff, b_valid_in;
   rtpd_pkg::result_type     b_res_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rtpd_pkg::kind_type       rsp_kind_ff;
   logic [SYM_W-1:0]         rsp_symbol_ff;
   logic                     rsp_last_ff;

   // decode view
   logic [rtpd_pkg::ONES_W-1:0] ones;
   logic                        run;
   logic [rtpd_pkg::LEN_W-1:0]  code_len;
   logic [CNT_W-1:0]            shift_amt;
   logic [ACC_W-1:0]            shifted;
   logic [rtpd_pkg::RANK_W-1:0] rank;
   logic                        bad_prefix, incomplete, bad, sym_code;
   logic                        emit_need, emit_ok, stall, step, eng_emit, eng_done;
   rtpd_pkg::result_type        eng_res;

   logic                        out_free, b_adv, b_free, req_fire;
   logic [rtpd_pkg::NB_W-1:0]   nb;
   logic                        ram_wr_en;
   logic [SYM_W-1:0]            ram_wr_addr, ram_wr_data, ram_rd_data;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign b_adv    = b_valid_ff && out_free;
   assign b_free   = !b_valid_ff || out_free;

   always_comb begin
      ones = '0;
      run  = 1'b1;
      for (int i = 0; i < rtpd_pkg::MAX_ONES; i++) begin
         if (run && (CNT_W'(i) < cnt_ff) && acc_ff[cnt_ff - CNT_W'(i) - CNT_W'(1)]) begin
            ones = ones + 3'd1;
         end else begin
            run = 1'b0;
         end
      end
      code_len   = rtpd_pkg::tier_len(ones);
      shift_amt  = cnt_ff - CNT_W'(code_len);
      shifted    = acc_ff >> shift_amt;
      rank       = rtpd_pkg::tier_base(ones)
                   + rtpd_pkg::RANK_W'(shifted[SYM_W-1:0] & rtpd_pkg::tier_mask(ones));
      bad_prefix = (ones == rtpd_pkg::ONES_W'(rtpd_pkg::MAX_ONES));
      incomplete = !bad_prefix && ((CNT_W'(ones) == cnt_ff) || (cnt_ff < CNT_W'(code_len)));
      bad        = bad_prefix || (!incomplete && rank[rtpd_pkg::RANK_W-1]);
      sym_code   = !bad && !incomplete;
      emit_need  = bad || sym_code || (incomplete && eos_ff);
      emit_ok    = nemit_ff < rtpd_pkg::EMIT_W'(rtpd_pkg::MAX_RESULTS);
      stall      = emit_need && emit_ok && !b_free;
      step       = busy_ff && !stall;
      eng_emit   = step && emit_need && emit_ok;
      eng_done   = step && (bad || incomplete);
      if (bad) begin
         eng_res.kind = rtpd_pkg::KIND_ERROR;
      end else if (incomplete) begin
         eng_res.kind = rtpd_pkg::KIND_END;
      end else begin
         eng_res.kind = rtpd_pkg::KIND_SYMBOL;
      end
      eng_res.sym_ok = sym_code && ivalid_ff[rank[SYM_W-1:0]];
      eng_res.last   = bad || incomplete;
   end

   assign req_tready = !busy_ff || eng_done;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      pos_in      = pos_ff;
      vbl_in      = vbl_ff;
      ivalid_in   = ivalid_ff;
      err_in      = err_ff;
      busy_in     = busy_ff;
      eos_in      = eos_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      nemit_in    = nemit_ff;
      nb          = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = req_tdata;
      ram_wr_data = pos_ff[SYM_W-1:0] - SYM_W'(1);

      // code extractor
      if (step) begin
         if (sym_code) begin
            cnt_in = cnt_ff - CNT_W'(code_len);
         end
         if (eng_emit) begin
            nemit_in = nemit_ff + rtpd_pkg::EMIT_W'(1);
         end
         if (eng_done) begin
            busy_in  = 1'b0;
            nemit_in = '0;
            acc_in   = acc_ff & ((ACC_W'(1) << cnt_ff) - ACC_W'(1));
            if (bad) begin
               err_in = 1'b1;
               cnt_in = '0;
               acc_in = '0;
            end
            if (eos_ff) begin
               pos_in    = '0;
               vbl_in    = '0;
               ivalid_in = '0;
               err_in    = 1'b0;
               cnt_in    = '0;
               acc_in    = '0;
            end
         end
      end

      // accepted beat, seen against the state left by the extractor
      if (req_fire) begin
         if (err_in) begin
            if (req_tlast) begin
               pos_in    = '0;
               vbl_in    = '0;
               ivalid_in = '0;
               err_in    = 1'b0;
               cnt_in    = '0;
               acc_in    = '0;
            end
         end else begin
            if (pos_in == '0) begin
               vbl_in = ((req_tdata == 8'd0) || (req_tdata > 8'd7)) ? 4'd8 : req_tdata[3:0];
               pos_in = POS_W'(1);
               busy_in = req_tlast;
            end else if (pos_in < POS_W'(rtpd_pkg::PAYLOAD_POS)) begin
               if (req_tlast) begin
                  busy_in = 1'b1;
               end else begin
                  if (!ivalid_in[req_tdata]) begin
                     ram_wr_en              = 1'b1;
                     ivalid_in[req_tdata]   = 1'b1;
                  end
                  pos_in = pos_in + POS_W'(1);
               end
            end else begin
               busy_in = 1'b1;
               nb      = req_tlast ? vbl_in : 4'd8;
            end
            if (busy_in) begin
               eos_in = req_tlast;
               acc_in = (acc_in << nb) | (ACC_W'(req_tdata) >> (4'd8 - nb));
               cnt_in = cnt_in + CNT_W'(nb);
            end
         end
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (eng_emit) begin
         b_valid_in = 1'b1;
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         vbl_ff       <= '0;
         ivalid_ff    <= '0;
         err_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         eos_ff       <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         nemit_ff     <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         vbl_ff       <= vbl_in;
         ivalid_ff    <= ivalid_in;
         err_ff       <= err_in;
         busy_ff      <= busy_in;
         eos_ff       <= eos_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         nemit_ff     <= nemit_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_emit) begin
         b_res_ff <= eng_res;
      end
      if (b_adv) begin
         rsp_kind_ff   <= b_res_ff.kind;
         rsp_last_ff   <= b_res_ff.last;
         rsp_symbol_ff <= ((b_res_ff.kind == rtpd_pkg::KIND_SYMBOL) && b_res_ff.sym_ok)
                          ? ram_rd_data : '0;
      end
   end

   rtpd_ram #(
      .WIDTH (SYM_W),
      .DEPTH (ASIZE)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (eng_emit && sym_code),
      .rd_addr (rank[SYM_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_symbol_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
